// File: hdl/mtsr_pkg.sv
// Shared types and constants for the two-run merge block.
package mtsr_pkg;

   localparam int MAX_WORDS = 64;
   localparam int ADDR_W    = $clog2(MAX_WORDS);
   localparam int CNT_W     = ADDR_W + 1;
   localparam int WORD_W    = 32;
   localparam int LEN_W     = 7;
   localparam int SPLIT_W   = 6;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = LEN_W;

   localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(14);
   localparam logic [SPLIT_W-1:0] SPLIT_RESET = SPLIT_W'(7);
   localparam logic [LEN_W-1:0]   LEN_MIN     = LEN_W'(2);
   localparam logic [LEN_W-1:0]   LEN_MAX     = LEN_W'(MAX_WORDS);

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT_POINT  = 1'b1;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_PRIME,
      ST_MERGE
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;   // store incoming word, advance load count
      logic init;   // block complete: latch sizes, rewind pointers
      logic step;   // emit one merged word
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic block_done;  // the word arriving now completes the block
      logic last_word;   // the word being emitted now is the final one
   } stat_type;

endpackage

// File: hdl/merge_two_sorted_runs.sv
// Loading: one word per cycle while busy is low; no result until the block is complete.
// Merge: after the completing word, ST_PRIME reads the heads of both runs, then registered results
// come one per cycle for the clamped block length; the dual-read word store sets this one-word-per-cycle pace.
// Busy is high in ST_PRIME and ST_MERGE.
// Synchronous reset clears the load count, the controller and the result strobe, and
// restores block_length 14 and split_point 7; the word store is not cleared.
module merge_two_sorted_runs (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_start,
   input  logic signed [mtsr_pkg::WORD_W-1:0]    req_value,
   output logic                                  busy,
   output logic                                  rsp_valid,
   output logic signed [mtsr_pkg::WORD_W-1:0]    rsp_merged_value,
   output logic                                  rsp_is_last,
   input  logic                                  csr_write,
   input  logic        [mtsr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [mtsr_pkg::CSR_DAT_W-1:0] csr_wdata
);

   logic [mtsr_pkg::LEN_W-1:0]   block_length_ff;
   logic [mtsr_pkg::SPLIT_W-1:0] split_point_ff;
   mtsr_pkg::cmd_type  cmd;
   mtsr_pkg::stat_type stat;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         block_length_ff <= mtsr_pkg::LEN_RESET;
         split_point_ff  <= mtsr_pkg::SPLIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            mtsr_pkg::CSR_BLOCK_LENGTH: begin
               block_length_ff <= csr_wdata[mtsr_pkg::LEN_W-1:0];
            end
            mtsr_pkg::CSR_SPLIT_POINT: begin
               split_point_ff <= csr_wdata[mtsr_pkg::SPLIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   mtsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_start (req_start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy)
   );

   mtsr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .block_length     (block_length_ff),
      .split_point      (split_point_ff),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_merged_value (rsp_merged_value),
      .rsp_is_last      (rsp_is_last)
   );

endmodule

// File: hdl/mtsr_ctrl.sv
// Controller state machine for the two-run merge block.
module mtsr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   input  mtsr_pkg::stat_type stat,
   output mtsr_pkg::cmd_type  cmd,
   output logic               busy
);

   mtsr_pkg::state_type state_ff, state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mtsr_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence load, prime and merge
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         mtsr_pkg::ST_LOAD: begin
            busy = 1'b0;
            if (req_start) begin
               cmd.load = 1'b1;
               if (stat.block_done) begin
                  cmd.init = 1'b1;
                  state_in = mtsr_pkg::ST_PRIME;
               end
            end
         end
         mtsr_pkg::ST_PRIME: begin
            // heads of both runs are read during this cycle
            state_in = mtsr_pkg::ST_MERGE;
         end
         mtsr_pkg::ST_MERGE: begin
            cmd.step = 1'b1;
            if (stat.last_word) begin
               state_in = mtsr_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = mtsr_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

// File: hdl/mtsr_datapath.sv
// Word store, run pointers, head compare and result register of the merge block.
module mtsr_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  mtsr_pkg::cmd_type                   cmd,
   output mtsr_pkg::stat_type                  stat,
   input  logic        [mtsr_pkg::LEN_W-1:0]   block_length,
   input  logic        [mtsr_pkg::SPLIT_W-1:0] split_point,
   input  logic signed [mtsr_pkg::WORD_W-1:0]  req_value,
   output logic                                rsp_valid,
   output logic signed [mtsr_pkg::WORD_W-1:0]  rsp_merged_value,
   output logic                                rsp_is_last
);

   logic signed [mtsr_pkg::WORD_W-1:0] mem [mtsr_pkg::MAX_WORDS];

   logic [mtsr_pkg::CNT_W-1:0] load_count_ff, load_count_in;
   logic [mtsr_pkg::CNT_W-1:0] len_ff, len_in;
   logic [mtsr_pkg::CNT_W-1:0] mid_ff, mid_in;
   logic [mtsr_pkg::CNT_W-1:0] a_ff, a_in;
   logic [mtsr_pkg::CNT_W-1:0] b_ff, b_in;
   logic [mtsr_pkg::CNT_W-1:0] k_ff, k_in;
   logic signed [mtsr_pkg::WORD_W-1:0] head_a_ff, head_b_ff;
   logic signed [mtsr_pkg::WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_last_ff, rsp_last_in;

   logic [mtsr_pkg::CNT_W-1:0] eff_len;
   logic [mtsr_pkg::CNT_W-1:0] eff_mid;
   logic                       take_a;

   // Clamp the configured sizes
   always_comb begin
      if (block_length < mtsr_pkg::LEN_MIN) begin
         eff_len = mtsr_pkg::LEN_MIN;
      end else if (block_length > mtsr_pkg::LEN_MAX) begin
         eff_len = mtsr_pkg::LEN_MAX;
      end else begin
         eff_len = block_length;
      end
      if (mtsr_pkg::CNT_W'(split_point) > eff_len) begin
         eff_mid = eff_len;
      end else begin
         eff_mid = mtsr_pkg::CNT_W'(split_point);
      end
   end

   assign stat.block_done = (load_count_ff + mtsr_pkg::CNT_W'(1)) >= eff_len;
   assign stat.last_word  = (k_ff == len_ff - mtsr_pkg::CNT_W'(1));

   // Pick the run whose head goes next; run A wins ties
   always_comb begin
      if (a_ff >= mid_ff) begin
         take_a = 1'b0;
      end else if (b_ff >= len_ff) begin
         take_a = 1'b1;
      end else begin
         take_a = head_a_ff <= head_b_ff;
      end
   end

   // Next values for counters, pointers and the result
   always_comb begin
      load_count_in = load_count_ff;
      len_in        = len_ff;
      mid_in        = mid_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      k_in          = k_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = 1'b0;
      if (cmd.load) begin
         load_count_in = load_count_ff + mtsr_pkg::CNT_W'(1);
      end
      if (cmd.init) begin
         load_count_in = '0;
         len_in        = eff_len;
         mid_in        = eff_mid;
         a_in          = '0;
         b_in          = eff_mid;
         k_in          = '0;
      end
      if (cmd.step) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = stat.last_word;
         k_in         = k_ff + mtsr_pkg::CNT_W'(1);
         if (take_a) begin
            rsp_value_in = head_a_ff;
            a_in         = a_ff + mtsr_pkg::CNT_W'(1);
         end else begin
            rsp_value_in = head_b_ff;
            b_in         = b_ff + mtsr_pkg::CNT_W'(1);
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         load_count_ff <= load_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      mid_ff       <= mid_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      k_ff         <= k_in;
      rsp_value_ff <= rsp_value_in;
   end

   // Word store: write on load, read both run heads at the next pointers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mem[load_count_ff[mtsr_pkg::ADDR_W-1:0]] <= req_value;
      end
      head_a_ff <= mem[a_in[mtsr_pkg::ADDR_W-1:0]];
      head_b_ff <= mem[b_in[mtsr_pkg::ADDR_W-1:0]];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_value = rsp_value_ff;
   assign rsp_is_last      = rsp_last_ff;

endmodule

// File: hdl/mtsr_checker.sv
// Port-level checks for the merge block and their bind to the top level.
module mtsr_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_is_last
);

   // Reset leaves the block idle with no result showing
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

   // A result only follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a merge in progress");

   // More results pending keeps the block busy
   a_busy_mid_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_last |-> busy)
      else $error("block idle before the final result");

   // The final result is not followed at once by another
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_last |=> !rsp_valid)
      else $error("result right after the final one");

endmodule

bind merge_two_sorted_runs mtsr_checker u_mtsr_checker (
   .clock       (clock),
   .reset       (reset),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_is_last (rsp_is_last)
);
